// ===== rtl/look_at_view_matrix_assert.svh =====
// Assertion macros used by the look-at view matrix top level.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LAVM_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LAVM_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lavm_pkg.sv =====
// Types, constants and fixed-point helpers for the look-at view matrix block.
package lavm_pkg;

	localparam int QW       = 32;
	localparam int FRAC     = 16;
	localparam int UW       = 18;
	localparam int MW       = 30;
	localparam int LW       = 31;
	localparam int SQW      = 63;
	localparam int SQ_STEPS = (SQW + 1) / 2;
	localparam int QB       = FRAC + 1;
	localparam int DW       = MW + FRAC + 2;
	localparam int CW       = 2 * UW + 1;
	localparam int EW       = 21;
	localparam int NUM_ROWS = 4;

	localparam logic [1:0] ROW_RIGHT = 2'd0;
	localparam logic [1:0] ROW_UP    = 2'd1;
	localparam logic [1:0] ROW_FWD   = 2'd2;
	localparam logic [1:0] ROW_LAST  = 2'd3;

	localparam logic [1:0] REG_UP_X = 2'd0;
	localparam logic [1:0] REG_UP_Y = 2'd1;
	localparam logic [1:0] REG_UP_Z = 2'd2;

	localparam logic signed [QW-1:0] Q_ONE    = 32'sh0001_0000;
	localparam logic signed [QW-1:0] UP_X_RST = 32'sh0;
	localparam logic signed [QW-1:0] UP_Y_RST = Q_ONE;
	localparam logic signed [QW-1:0] UP_Z_RST = 32'sh0;

	typedef struct packed {
		logic signed [QW-1:0] eye_x;
		logic signed [QW-1:0] eye_y;
		logic signed [QW-1:0] eye_z;
		logic signed [QW-1:0] aim_x;
		logic signed [QW-1:0] aim_y;
		logic signed [QW-1:0] aim_z;
	} req_t;

	typedef struct packed {
		logic [1:0]           row_index;
		logic signed [QW-1:0] col_a;
		logic signed [QW-1:0] col_b;
		logic signed [QW-1:0] col_c;
		logic signed [QW-1:0] col_d;
		logic                 last_row;
		logic                 degenerate;
	} res_t;

	// Q32.32 to Q16.16, half away from zero.
	function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] x);
		logic [63:0] m;
		logic [63:0] r;
		m = x[63] ? (~x + 64'd1) : x;
		r = (m + 64'd32768) >> FRAC;
		return x[63] ? $signed(~r + 64'd1) : $signed(r);
	endfunction

	function automatic logic signed [QW-1:0] sat_q32(input logic signed [63:0] x);
		if (x > 64'sh0000_0000_7fff_ffff)
			return 32'sh7fff_ffff;
		else if (x < 64'shffff_ffff_8000_0000)
			return 32'sh8000_0000;
		else
			return x[QW-1:0];
	endfunction

endpackage

// ===== rtl/lavm_norm.sv =====
// Pipelined 3-vector normalizer: range shift, sum of squares, square root, divide.
module lavm_norm #(
	parameter int W    = 33,
	parameter int SB_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_vld,
	input  logic [2:0][W-1:0]              src_vec,
	input  logic [SB_W-1:0]                src_sb,
	output logic                           nrm_vld,
	output logic [2:0][lavm_pkg::UW-1:0]   nrm_vec,
	output logic                           nrm_zero,
	output logic [SB_W-1:0]                nrm_sb
);

	localparam int MW  = lavm_pkg::MW;
	localparam int PW  = $clog2(W);
	localparam int SQW = lavm_pkg::SQW;
	localparam int NS  = lavm_pkg::SQ_STEPS;
	localparam int DW  = lavm_pkg::DW;
	localparam int QB  = lavm_pkg::QB;
	localparam int LW  = lavm_pkg::LW;
	localparam int UW  = lavm_pkg::UW;
	localparam logic [PW-1:0] TOP = PW'(MW - 1);

	typedef struct packed {
		logic [2:0][MW-1:0] m;
		logic [2:0]         neg;
		logic               zero;
		logic [SB_W-1:0]    sb;
	} scar_t;

	typedef struct packed {
		logic [LW-1:0]   len;
		logic [2:0]      neg;
		logic            zero;
		logic [SB_W-1:0] sb;
	} dcar_t;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [2:0][W-1:0]  mag_s1, mag_s2, mag_s3;
	logic [2:0]         neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [SB_W-1:0]    sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;
	logic [W-1:0]       mx_s2;
	logic [PW-1:0]      pos_s3;
	logic               zero_s3, zero_s4, zero_s5;
	logic [2:0][MW-1:0] m_s4, m_s5;
	logic [2:0][2*MW-1:0] sq_s5;
	logic [PW-1:0]      pos_c;

	logic               sq_v [0:NS];
	logic [SQW-1:0]     sq_n [0:NS];
	logic [SQW-1:0]     sq_r [0:NS];
	scar_t              sq_c [0:NS];

	logic               dv_v [0:QB];
	logic [2:0][DW-1:0] dv_rem [0:QB];
	logic [2:0][QB-1:0] dv_q [0:QB];
	dcar_t              dv_c [0:QB];

	logic [LW-1:0]      len_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			sq_v[0]   <= 1'b0;
			dv_v[0]   <= 1'b0;
			nrm_vld   <= 1'b0;
		end else begin
			vld_s1    <= src_vld;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			sq_v[0]   <= vld_s5;
			dv_v[0]   <= sq_v[NS];
			nrm_vld   <= dv_v[QB];
		end
	end

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < W; b++) begin
			if (mx_s2[b])
				pos_c = PW'(b);
		end
	end

	assign len_c = sq_r[NS][LW-1:0];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= src_vec[i][W-1];
			mag_s1[i] <= src_vec[i][W-1] ? (~src_vec[i] + W'(1)) : src_vec[i];
		end
		sb_s1 <= src_sb;

		mx_s2  <= (mag_s1[0] > mag_s1[1]) ?
			((mag_s1[0] > mag_s1[2]) ? mag_s1[0] : mag_s1[2]) :
			((mag_s1[1] > mag_s1[2]) ? mag_s1[1] : mag_s1[2]);
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		sb_s2  <= sb_s1;

		pos_s3  <= pos_c;
		zero_s3 <= (mx_s2 == '0);
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;
		sb_s3   <= sb_s2;

		for (int i = 0; i < 3; i++) begin
			if (pos_s3 >= TOP)
				m_s4[i] <= MW'(mag_s3[i] >> (pos_s3 - TOP));
			else
				m_s4[i] <= MW'(mag_s3[i] << (TOP - pos_s3));
		end
		zero_s4 <= zero_s3;
		neg_s4  <= neg_s3;
		sb_s4   <= sb_s3;

		for (int i = 0; i < 3; i++)
			sq_s5[i] <= m_s4[i] * m_s4[i];
		m_s5    <= m_s4;
		zero_s5 <= zero_s4;
		neg_s5  <= neg_s4;
		sb_s5   <= sb_s4;

		sq_n[0]      <= SQW'(sq_s5[0]) + SQW'(sq_s5[1]) + SQW'(sq_s5[2]);
		sq_r[0]      <= '0;
		sq_c[0].m    <= m_s5;
		sq_c[0].neg  <= neg_s5;
		sq_c[0].zero <= zero_s5;
		sq_c[0].sb   <= sb_s5;

		for (int i = 0; i < 3; i++)
			dv_rem[0][i] <= DW'({sq_c[NS].m[i], {lavm_pkg::FRAC{1'b0}}}) + DW'(len_c >> 1);
		dv_q[0]      <= '0;
		dv_c[0].len  <= len_c;
		dv_c[0].neg  <= sq_c[NS].neg;
		dv_c[0].zero <= sq_c[NS].zero;
		dv_c[0].sb   <= sq_c[NS].sb;

		for (int i = 0; i < 3; i++) begin
			if (dv_c[QB].zero)
				nrm_vec[i] <= '0;
			else if (dv_c[QB].neg[i])
				nrm_vec[i] <= ~UW'(dv_q[QB][i]) + UW'(1);
			else
				nrm_vec[i] <= UW'(dv_q[QB][i]);
		end
		nrm_zero <= dv_c[QB].zero;
		nrm_sb   <= dv_c[QB].sb;
	end

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [SQW-1:0] BITV = SQW'(1) << (SQW - 1 - 2 * k);
		logic [SQW-1:0] trial;

		assign trial = sq_r[k] + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v[k+1] <= 1'b0;
			else
				sq_v[k+1] <= sq_v[k];
		end

		always_ff @(posedge clk) begin
			sq_c[k+1] <= sq_c[k];
			if (sq_n[k] >= trial) begin
				sq_n[k+1] <= sq_n[k] - trial;
				sq_r[k+1] <= (sq_r[k] >> 1) + BITV;
			end else begin
				sq_n[k+1] <= sq_n[k];
				sq_r[k+1] <= sq_r[k] >> 1;
			end
		end
	end

	for (genvar t = 0; t < QB; t++) begin : g_div
		localparam int SH = QB - 1 - t;
		logic [DW-1:0] dsor;

		assign dsor = DW'(dv_c[t].len) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v[t+1] <= 1'b0;
			else
				dv_v[t+1] <= dv_v[t];
		end

		always_ff @(posedge clk) begin
			dv_c[t+1] <= dv_c[t];
			for (int i = 0; i < 3; i++) begin
				if (dv_rem[t][i] >= dsor) begin
					dv_rem[t+1][i] <= dv_rem[t][i] - dsor;
					dv_q[t+1][i]   <= dv_q[t][i] | (QB'(1) << SH);
				end else begin
					dv_rem[t+1][i] <= dv_rem[t][i];
					dv_q[t+1][i]   <= dv_q[t][i];
				end
			end
		end
	end

endmodule

// ===== rtl/lavm_cross.sv =====
// Two-stage exact cross product of two signed 3-vectors with sideband.
module lavm_cross #(
	parameter int AW   = 18,
	parameter int SB_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_vld,
	input  logic [2:0][AW-1:0]    src_a,
	input  logic [2:0][AW-1:0]    src_b,
	input  logic [SB_W-1:0]       src_sb,
	output logic                  crs_vld,
	output logic [2:0][2*AW:0]    crs_vec,
	output logic [SB_W-1:0]       crs_sb
);

	localparam int PW = 2 * AW;

	logic                 vld_s1;
	logic [SB_W-1:0]      sb_s1;
	logic signed [PW-1:0] pr_s1 [0:5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			crs_vld <= 1'b0;
		end else begin
			vld_s1  <= src_vld;
			crs_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pr_s1[0] <= $signed(src_a[1]) * $signed(src_b[2]);
		pr_s1[1] <= $signed(src_a[2]) * $signed(src_b[1]);
		pr_s1[2] <= $signed(src_a[2]) * $signed(src_b[0]);
		pr_s1[3] <= $signed(src_a[0]) * $signed(src_b[2]);
		pr_s1[4] <= $signed(src_a[0]) * $signed(src_b[1]);
		pr_s1[5] <= $signed(src_a[1]) * $signed(src_b[0]);
		sb_s1    <= src_sb;

		crs_vec[0] <= (PW+1)'(pr_s1[0]) - (PW+1)'(pr_s1[1]);
		crs_vec[1] <= (PW+1)'(pr_s1[2]) - (PW+1)'(pr_s1[3]);
		crs_vec[2] <= (PW+1)'(pr_s1[4]) - (PW+1)'(pr_s1[5]);
		crs_sb     <= sb_s1;
	end

endmodule

// ===== rtl/lavm_dots.sv =====
// Three-lane dot products against the eye point, rounded and saturated to Q16.16.
module lavm_dots #(
	parameter int AW   = 21,
	parameter int SB_W = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               src_vld,
	input  logic [2:0][2:0][AW-1:0]            src_vec,
	input  logic [2:0][lavm_pkg::QW-1:0]       src_eye,
	input  logic [SB_W-1:0]                    src_sb,
	output logic                               dot_vld,
	output logic [2:0][lavm_pkg::QW-1:0]       dot_val,
	output logic [SB_W-1:0]                    dot_sb
);

	localparam int QW = lavm_pkg::QW;
	localparam int PW = AW + QW;
	localparam int SW = PW + 2;

	logic                 vld_s1, vld_s2;
	logic [SB_W-1:0]      sb_s1, sb_s2;
	logic signed [PW-1:0] pr_s1 [0:2][0:2];
	logic signed [SW-1:0] sum_s2 [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			dot_vld <= 1'b0;
		end else begin
			vld_s1  <= src_vld;
			vld_s2  <= vld_s1;
			dot_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			for (int i = 0; i < 3; i++)
				pr_s1[l][i] <= $signed(src_vec[l][i]) * $signed(src_eye[i]);
			sum_s2[l]  <= SW'(pr_s1[l][0]) + SW'(pr_s1[l][1]) + SW'(pr_s1[l][2]);
			dot_val[l] <= lavm_pkg::sat_q32(lavm_pkg::rnd_q16(64'(sum_s2[l])));
		end
		sb_s1  <= src_sb;
		sb_s2  <= sb_s1;
		dot_sb <= sb_s2;
	end

endmodule

// ===== rtl/look_at_view_matrix.sv =====
// Top level of the look-at view matrix generator.
//
// Command channel: req holds eye and aim points (signed Q16.16); a transfer
// happens at a rising edge with start high and busy low. busy stays high
// after each transfer while a gap counter runs down, blocking new items.
// The world up vector comes from three registers written through wr_en,
// wr_idx and wr_data (index 0..2 = x, y, z; index 3 is ignored). The user
// must write them only while no item is in flight; the block itself does not
// enforce this. The up vector is normalized per item.
// Results: four rows per item on result, each valid for one cycle with done
// high, rows 0..3 in consecutive cycles, last_row on row 3. The receiver
// cannot stall, and none is needed.
// The depth is set by two normalizer passes in series (each with a 32-step
// square root and a 17-step divider, one bit per stage), plus the input
// register, the cross products, the lane register, the dot products and the
// output register.
// Reset clears all valid bits, the output strobe and busy, and loads the up
// vector with (0, 1.0, 0).
`include "look_at_view_matrix_assert.svh"

module look_at_view_matrix (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  lavm_pkg::req_t          req,
	input  logic                    wr_en,
	input  logic [1:0]              wr_idx,
	input  logic [lavm_pkg::QW-1:0] wr_data,
	output logic                    done,
	output lavm_pkg::res_t          result
);

	localparam int QW = lavm_pkg::QW;
	localparam int UW = lavm_pkg::UW;
	localparam int CW = lavm_pkg::CW;
	localparam int EW = lavm_pkg::EW;
	localparam int PB = 3 * QW;

	typedef struct packed {
		logic [2:0][UW-1:0] f;
		logic [2:0][QW-1:0] p;
		logic               deg;
	} c1_sb_t;

	typedef struct packed {
		logic [2:0][UW-1:0] r;
		logic [2:0][UW-1:0] f;
		logic [2:0][QW-1:0] p;
		logic               deg;
	} c2_sb_t;

	typedef struct packed {
		logic [2:0][2:0][EW-1:0] v;
		logic                    deg;
	} dt_sb_t;

	logic [QW-1:0] up_x_q, up_y_q, up_z_q;
	logic [1:0]    gap_q;
	logic          acc;

	logic                  vld_s1;
	logic [2:0][QW-1:0]    p_s1;
	logic [2:0][QW:0]      d_s1;
	logic [2:0][QW-1:0]    up_s1;

	logic                  upn_vld, fwn_vld, fwn_mark;
	logic [2:0][UW-1:0]    upn_vec, fwn_vec;
	logic                  upn_zero, fwn_zero;
	logic [PB-1:0]         upn_p;

	c1_sb_t                c1_in, c1_out;
	logic                  c1_vld;
	logic [2:0][CW-1:0]    c1_vec;

	logic                  rn_vld, rn_zero;
	logic [2:0][UW-1:0]    rn_vec;
	c1_sb_t                rn_sb;

	c2_sb_t                c2_in, c2_out;
	logic                  c2_vld;
	logic [2:0][CW-1:0]    c2_vec;

	logic                     vld_s3;
	logic [2:0][2:0][EW-1:0]  v_s3;
	logic [2:0][QW-1:0]       p_s3;
	logic                     deg_s3;

	dt_sb_t                dt_in, dt_out;
	logic                  dt_vld;
	logic [2:0][QW-1:0]    dt_val;

	lavm_pkg::res_t        row_c [0:lavm_pkg::NUM_ROWS-1];
	lavm_pkg::res_t        hold_q [0:lavm_pkg::NUM_ROWS-1];
	lavm_pkg::res_t        res_q;
	logic                  done_q;
	logic [1:0]            cnt_q;

	assign acc  = start && !busy;
	assign busy = (gap_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q <= lavm_pkg::UP_X_RST;
			up_y_q <= lavm_pkg::UP_Y_RST;
			up_z_q <= lavm_pkg::UP_Z_RST;
		end else if (wr_en) begin
			case (wr_idx)
				lavm_pkg::REG_UP_X: up_x_q <= wr_data;
				lavm_pkg::REG_UP_Y: up_y_q <= wr_data;
				lavm_pkg::REG_UP_Z: up_z_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= 2'd0;
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (acc)
				gap_q <= 2'(lavm_pkg::NUM_ROWS - 1);
			else if (gap_q != 2'd0)
				gap_q <= gap_q - 2'd1;
			vld_s1 <= acc;
			vld_s3 <= c2_vld;
			if (dt_vld) begin
				done_q <= 1'b1;
				cnt_q  <= lavm_pkg::ROW_UP;
			end else if (cnt_q != lavm_pkg::ROW_RIGHT) begin
				done_q <= 1'b1;
				cnt_q  <= cnt_q + 2'd1;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0]  <= req.eye_x;
		p_s1[1]  <= req.eye_y;
		p_s1[2]  <= req.eye_z;
		d_s1[0]  <= {req.aim_x[QW-1], req.aim_x} - {req.eye_x[QW-1], req.eye_x};
		d_s1[1]  <= {req.aim_y[QW-1], req.aim_y} - {req.eye_y[QW-1], req.eye_y};
		d_s1[2]  <= {req.aim_z[QW-1], req.aim_z} - {req.eye_z[QW-1], req.eye_z};
		up_s1[0] <= up_x_q;
		up_s1[1] <= up_y_q;
		up_s1[2] <= up_z_q;
	end

	lavm_norm #(.W(QW), .SB_W(PB)) u_up_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_vld  (vld_s1),
		.src_vec  (up_s1),
		.src_sb   (p_s1),
		.nrm_vld  (upn_vld),
		.nrm_vec  (upn_vec),
		.nrm_zero (upn_zero),
		.nrm_sb   (upn_p)
	);

	lavm_norm #(.W(QW + 1), .SB_W(1)) u_fwd_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_vld  (vld_s1),
		.src_vec  (d_s1),
		.src_sb   (vld_s1),
		.nrm_vld  (fwn_vld),
		.nrm_vec  (fwn_vec),
		.nrm_zero (fwn_zero),
		.nrm_sb   (fwn_mark)
	);

	assign c1_in.f   = fwn_vec;
	assign c1_in.p   = upn_p;
	assign c1_in.deg = upn_zero || fwn_zero;

	lavm_cross #(.AW(UW), .SB_W($bits(c1_sb_t))) u_right_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.src_vld (fwn_vld && fwn_mark),
		.src_a   (fwn_vec),
		.src_b   (upn_vec),
		.src_sb  (c1_in),
		.crs_vld (c1_vld),
		.crs_vec (c1_vec),
		.crs_sb  (c1_out)
	);

	lavm_norm #(.W(CW), .SB_W($bits(c1_sb_t))) u_right_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_vld  (c1_vld),
		.src_vec  (c1_vec),
		.src_sb   (c1_out),
		.nrm_vld  (rn_vld),
		.nrm_vec  (rn_vec),
		.nrm_zero (rn_zero),
		.nrm_sb   (rn_sb)
	);

	assign c2_in.r   = rn_vec;
	assign c2_in.f   = rn_sb.f;
	assign c2_in.p   = rn_sb.p;
	assign c2_in.deg = rn_sb.deg || rn_zero;

	lavm_cross #(.AW(UW), .SB_W($bits(c2_sb_t))) u_up_cross (
		.clk     (clk),
		.arst_n  (arst_n),
		.src_vld (rn_vld),
		.src_a   (rn_vec),
		.src_b   (rn_sb.f),
		.src_sb  (c2_in),
		.crs_vld (c2_vld),
		.crs_vec (c2_vec),
		.crs_sb  (c2_out)
	);

	// lanes: 0 right, 1 true up, 2 forward
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			v_s3[0][i] <= EW'($signed(c2_out.r[i]));
			v_s3[1][i] <= EW'(lavm_pkg::rnd_q16(64'($signed(c2_vec[i]))));
			v_s3[2][i] <= EW'($signed(c2_out.f[i]));
		end
		p_s3   <= c2_out.p;
		deg_s3 <= c2_out.deg;
	end

	assign dt_in.v   = v_s3;
	assign dt_in.deg = deg_s3;

	lavm_dots #(.AW(EW), .SB_W($bits(dt_sb_t))) u_dots (
		.clk     (clk),
		.arst_n  (arst_n),
		.src_vld (vld_s3),
		.src_vec (v_s3),
		.src_eye (p_s3),
		.src_sb  (dt_in),
		.dot_vld (dt_vld),
		.dot_val (dt_val),
		.dot_sb  (dt_out)
	);

	always_comb begin
		for (int k = 0; k < lavm_pkg::NUM_ROWS; k++) begin
			row_c[k].row_index  = 2'(k);
			row_c[k].last_row   = (2'(k) == lavm_pkg::ROW_LAST);
			row_c[k].degenerate = dt_out.deg;
		end
		for (int k = 0; k < 2; k++) begin
			row_c[k].col_a = QW'($signed(dt_out.v[k][0]));
			row_c[k].col_b = QW'($signed(dt_out.v[k][1]));
			row_c[k].col_c = QW'($signed(dt_out.v[k][2]));
			row_c[k].col_d = (dt_val[k] == 32'sh8000_0000) ? 32'sh7fff_ffff :
				(~dt_val[k] + QW'(1));
		end
		row_c[2].col_a = ~QW'($signed(dt_out.v[2][0])) + QW'(1);
		row_c[2].col_b = ~QW'($signed(dt_out.v[2][1])) + QW'(1);
		row_c[2].col_c = ~QW'($signed(dt_out.v[2][2])) + QW'(1);
		row_c[2].col_d = dt_val[2];
		row_c[3].col_a = '0;
		row_c[3].col_b = '0;
		row_c[3].col_c = '0;
		row_c[3].col_d = lavm_pkg::Q_ONE;
	end

	always_ff @(posedge clk) begin
		if (dt_vld) begin
			hold_q <= row_c;
			res_q  <= row_c[0];
		end else begin
			res_q  <= hold_q[cnt_q];
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`LAVM_CHK_NEXT(a_accept_busy, acc, busy, "busy low after a transfer")
	`LAVM_CHK_NEXT(a_rows_back_to_back, done && !result.last_row, done, "row sequence broken")
	`LAVM_CHK_NOW(a_last_marks_row3, done, result.last_row == (result.row_index == lavm_pkg::ROW_LAST), "last_row mismatch")
	`LAVM_CHK_NEXT(a_deg_steady, done && !result.last_row, $stable(result.degenerate), "degenerate changed within item")
	`LAVM_CHK_NOW(a_no_overlap, dt_vld, !done || result.last_row, "new matrix while rows pending")
	`LAVM_CHK_NOW(a_norm_aligned, fwn_vld, upn_vld, "normalizer outputs out of step")

endmodule

// ===== tb/look_at_view_matrix_tb.sv =====
// Self-checking testbench for the look-at view matrix generator: directed and random cameras.
module look_at_view_matrix_tb;
	import lavm_pkg::*;

	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 140;

	typedef logic signed [63:0] vec3_t [3];

	typedef struct {
		req_t item;
		bit   typed;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	req_t       req = '0;
	logic       wr_en = 1'b0;
	logic [1:0] wr_idx = '0;
	logic [QW-1:0] wr_data = '0;
	logic       done;
	res_t       result;

	logic signed [QW-1:0] world_up [3];
	res_t  rows_due[$];
	int    mismatches = 0;
	int    idle_cycles = 0;
	int    burst_left = 0;
	stim_row_t directed[$];

	look_at_view_matrix uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		return x < 0 ? 64'(-x) : 64'(x);
	endfunction

	function automatic logic signed [63:0] round_q16(input logic signed [63:0] x);
		logic [63:0] m;
		m = (mag64(x) + 64'd32768) >> 16;
		return x < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// returns 0 on a zero-length vector
	function automatic bit unit_vec(input vec3_t v, output vec3_t o);
		logic [63:0] m [3];
		logic [63:0] mx, sum, len, q;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag64(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 3; i++)
				o[i] = 0;
			return 0;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			sum += m[i] * m[i];
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 16) + len / 2) / len;
			o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
		end
		return 1;
	endfunction

	function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t o);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic logic signed [63:0] translation(input vec3_t a, input vec3_t p);
		logic signed [63:0] t;
		t = round_q16(a[0] * p[0] + a[1] * p[1] + a[2] * p[2]);
		if (t > 64'sd2147483647)
			t = 64'sd2147483647;
		if (t < -64'sd2147483648)
			t = -64'sd2147483648;
		return t;
	endfunction

	function automatic res_t make_row(input logic [1:0] k, input vec3_t v,
			input logic signed [63:0] d, input bit deg);
		res_t r;
		r.row_index = k;
		r.col_a = v[0][31:0];
		r.col_b = v[1][31:0];
		r.col_c = v[2][31:0];
		r.col_d = d[31:0];
		r.last_row = (k == ROW_LAST);
		r.degenerate = deg;
		return r;
	endfunction

	function automatic void predict_view(input req_t x);
		vec3_t p, dir, upv, un, f, cx, r, u, fn, zero;
		bit ok;
		logic signed [63:0] t;
		p[0] = x.eye_x; p[1] = x.eye_y; p[2] = x.eye_z;
		dir[0] = 64'(x.aim_x) - p[0];
		dir[1] = 64'(x.aim_y) - p[1];
		dir[2] = 64'(x.aim_z) - p[2];
		for (int i = 0; i < 3; i++) begin
			upv[i] = world_up[i];
			zero[i] = 0;
		end
		ok = unit_vec(upv, un);
		ok = unit_vec(dir, f) && ok;
		cross3(f, un, cx);
		ok = unit_vec(cx, r) && ok;
		cross3(r, f, cx);
		for (int i = 0; i < 3; i++) begin
			u[i] = round_q16(cx[i]);
			fn[i] = -f[i];
		end
		t = -translation(r, p);
		if (t > 64'sd2147483647)
			t = 64'sd2147483647;
		rows_due.push_back(make_row(ROW_RIGHT, r, t, !ok));
		t = -translation(u, p);
		if (t > 64'sd2147483647)
			t = 64'sd2147483647;
		rows_due.push_back(make_row(ROW_UP, u, t, !ok));
		rows_due.push_back(make_row(ROW_FWD, fn, translation(f, p), !ok));
		rows_due.push_back(make_row(ROW_LAST, zero, 64'(Q_ONE), !ok));
	endfunction

	function automatic void push_zero_view();
		vec3_t zero;
		for (int i = 0; i < 3; i++)
			zero[i] = 0;
		rows_due.push_back(make_row(ROW_RIGHT, zero, 0, 1'b1));
		rows_due.push_back(make_row(ROW_UP, zero, 0, 1'b1));
		rows_due.push_back(make_row(ROW_FWD, zero, 0, 1'b1));
		rows_due.push_back(make_row(ROW_LAST, zero, 64'(Q_ONE), 1'b1));
	endfunction

	// start stays high across back-to-back transfers
	task automatic send_view(input req_t x, input bit typed);
		start <= 1'b1;
		req <= x;
		do
			@(posedge clk);
		while (busy);
		if (typed)
			push_zero_view();
		else
			predict_view(x);
	endtask

	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
		gap = $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [QW-1:0] val);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		@(posedge clk);
		if (idx != REG_NONE)
			world_up[idx] = val;
	endtask

	task automatic set_up(input logic [QW-1:0] x, input logic [QW-1:0] y,
			input logic [QW-1:0] z);
		write_reg(REG_UP_X, x);
		write_reg(REG_UP_Y, y);
		write_reg(REG_UP_Z, z);
		write_reg(REG_NONE, $urandom);
		wr_en <= 1'b0;
	endtask

	function automatic logic [QW-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
		endcase
	endfunction

	function automatic req_t rand_view();
		req_t x;
		int mode;
		x.eye_x = rand_coord(); x.eye_y = rand_coord(); x.eye_z = rand_coord();
		mode = $urandom_range(0, 19);
		if (mode == 0) begin
			x.aim_x = x.eye_x; x.aim_y = x.eye_y; x.aim_z = x.eye_z;
		end else if (mode == 1) begin
			x.aim_x = x.eye_x + world_up[0];
			x.aim_y = x.eye_y + world_up[1];
			x.aim_z = x.eye_z + world_up[2];
		end else begin
			x.aim_x = rand_coord(); x.aim_y = rand_coord(); x.aim_z = rand_coord();
		end
		return x;
	endfunction

	function automatic void add_row(input logic [QW-1:0] ex, input logic [QW-1:0] ey,
			input logic [QW-1:0] ez, input logic [QW-1:0] ax, input logic [QW-1:0] ay,
			input logic [QW-1:0] az, input bit typed);
		stim_row_t s;
		s.item = '{ex, ey, ez, ax, ay, az};
		s.typed = typed;
		directed.push_back(s);
	endfunction

	always @(posedge clk) begin
		if (done) begin
			if (rows_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row %h", result);
			end else begin
				if (result.row_index !== rows_due[0].row_index
						|| result.col_a !== rows_due[0].col_a
						|| result.col_b !== rows_due[0].col_b
						|| result.col_c !== rows_due[0].col_c
						|| result.col_d !== rows_due[0].col_d
						|| result.last_row !== rows_due[0].last_row
						|| result.degenerate !== rows_due[0].degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("row mismatch: expected %h actual %h", rows_due[0], result);
				end
				void'(rows_due.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		world_up[0] = UP_X_RST;
		world_up[1] = UP_Y_RST;
		world_up[2] = UP_Z_RST;
		add_row(0, 0, 0, 0, 0, 0, 1'b1);
		add_row(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
		add_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		add_row(0, 0, 0, 0, Q_ONE, 0, 1'b0);
		add_row(0, 0, 0, 0, 0, 32'hffff_0000, 1'b0);
		add_row(0, 0, 0, Q_ONE, 0, 0, 1'b0);
		add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		add_row(32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 1'b0);
		add_row(32'h8000_0000, 0, 32'h7fff_ffff, 1, 1, 1, 1'b0);
		add_row(32'h0003_0000, 32'h0002_0000, 32'h0005_0000, 0, 0, 0, 1'b0);
		add_row(1, 0, 0, 0, 0, 0, 1'b0);
		add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_view(directed[i].item, directed[i].typed);
			pace();
		end

		for (int phase = 0; phase < 6; phase++) begin
			wait_idle();
			case (phase)
				0: set_up(0, 0, 0);
				1: set_up(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
				2: set_up(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
				3: set_up(1, 0, 32'hffff_ffff);
				default: set_up($urandom, $urandom, $urandom);
			endcase
			for (int n = 0; n < 80; n++) begin
				send_view(rand_view(), 1'b0);
				pace();
			end
		end

		start <= 1'b0;
		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lavm_pkg.sv
rtl/lavm_norm.sv
rtl/lavm_cross.sv
rtl/lavm_dots.sv
rtl/look_at_view_matrix.sv
tb/look_at_view_matrix_tb.sv
